### hw/rtl/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg: shared types, constants and arithmetic helpers
// Q16.16 / Q48.16 saturating arithmetic and sizes for the FM scorer.
// ----------------------------------------------------------------------------
package fms_pkg;

  localparam int MaxFeatures = 1024;
  localparam int MaxFactors  = 8;
  localparam int MaxTargets  = 4;

  localparam int FeatW    = $clog2(MaxFeatures);
  localparam int FacW     = $clog2(MaxFactors);
  localparam int TgtW     = $clog2(MaxTargets);
  localparam int LinAddrW = TgtW + FeatW;
  localparam int FacAddrW = TgtW + FeatW + FacW;
  localparam int LinDepth = MaxTargets * MaxFeatures;
  localparam int FacDepth = MaxTargets * MaxFeatures * MaxFactors;

  typedef enum logic [2:0] {
    OP_LINEAR  = 3'd0,
    OP_FACTOR  = 3'd1,
    OP_BIAS    = 3'd2,
    OP_FEATURE = 3'd3,
    OP_EVAL    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_FEATURES = 2'd0,
    CFG_FACTORS  = 2'd1,
    CFG_TARGETS  = 2'd2
  } cfg_idx_e;

  localparam logic signed [63:0] SatMax = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SatMin = {1'b1, {63{1'b0}}};

  // shared multiplier control
  typedef struct packed {
    logic              start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic signed [63:0] res;
  } mul_rsp_t;

  function automatic logic signed [63:0] sext32(input logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SatMin : SatMax;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SatMin : SatMax;
    end
    return s[63:0];
  endfunction

  // divide by two, rounding toward zero
  function automatic logic signed [63:0] half(input logic signed [63:0] d);
    logic signed [63:0] t;
    t = d + {63'd0, d[63]};
    return t >>> 1;
  endfunction

endpackage

### hw/rtl/fms_req_if.sv
// ----------------------------------------------------------------------------
// fms_req_if: request channel
// Opcode, target, indices, value and last flag with valid/ready.
// ----------------------------------------------------------------------------
interface fms_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [1:0]        target;
  logic [9:0]        feature_index;
  logic [2:0]        factor_index;
  logic signed [31:0] value;
  logic              last;

  modport source (output valid, opcode, target, feature_index, factor_index, value, last,
                  input ready);
  modport sink (input valid, opcode, target, feature_index, factor_index, value, last,
                output ready);
endinterface

### hw/rtl/fms_rsp_if.sv
// ----------------------------------------------------------------------------
// fms_rsp_if: score channel
// Saturated Q48.16 score and target reject flag with valid/ready.
// ----------------------------------------------------------------------------
interface fms_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [63:0] score;
  logic              target_rejected;

  modport source (output valid, score, target_rejected, input ready);
  modport sink (input valid, score, target_rejected, output ready);
endinterface

### hw/rtl/fms_cfg_if.sv
// ----------------------------------------------------------------------------
// fms_cfg_if: configuration write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface fms_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/fms_ram.sv
// ----------------------------------------------------------------------------
// fms_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fms_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hw/rtl/fms_mul.sv
// ----------------------------------------------------------------------------
// fms_mul: sequential Q16.16 multiplier
// 64x64 magnitude product from four 32x32 partials, scaled by 2^-16,
// truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module fms_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fms_pkg::mul_req_t req_i,
  output fms_pkg::mul_rsp_t rsp_o
);

  logic         busy_q, busy_d;
  logic         fin_q, fin_d;
  logic         done_q, done_d;
  logic [1:0]   step_q, step_d;
  logic [63:0]  ua_q, ua_d, ub_q, ub_d;
  logic         neg_q, neg_d;
  logic [127:0] acc_q, acc_d;
  logic signed [63:0] res_q, res_d;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  mag;

  assign pa = step_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign pb = step_q[0] ? ub_q[63:32] : ub_q[31:0];
  assign pp = pa * pb;
  assign mag = acc_q[79:16];

  always_comb begin
    unique case (step_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    step_d = step_q;
    ua_d   = ua_q;
    ub_d   = ub_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = 2'd0;
      ua_d   = req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
      ub_d   = req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);
      neg_d  = req_i.a[63] ^ req_i.b[63];
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d  = acc_q + pp_sh;
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
    if (fin_q) begin
      done_d = 1'b1;
      if (|acc_q[127:80]) begin
        res_d = neg_q ? fms_pkg::SatMin : fms_pkg::SatMax;
      end else if (neg_q) begin
        res_d = mag[63] ? fms_pkg::SatMin : -$signed(mag);
      end else begin
        res_d = mag[63] ? fms_pkg::SatMax : $signed(mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

### hw/rtl/factorization_machine_score_core.sv
// ----------------------------------------------------------------------------
// factorization_machine_score_core: order-2 factorization machine scorer
// Loads weight/factor/bias tables, accumulates sparse features, emits
// linear + bias + sum_k (s1^2 - s2)/2 as a saturated Q48.16 score.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req_i   | in  | valid/ready | opcode, target, feature_index, factor_index,
//          |     |             | value, last
//  rsp_o   | out | valid/ready | score, target_rejected
//  cfg_i   | in  | valid/ready | index, data (always ready)
//
// Loads are written as they are accepted. Every product of a contributing
// feature goes through the one shared sequential multiplier: the linear
// one, then two per factor in use, with a table read ahead of the linear
// product and ahead of each factor pair. Scoring has a start step, then
// one multiply and one add step per factor. Async active-low reset clears
// control and accumulators and sets config to full size; tables hold
// garbage until loaded. A finished score waits in a holding slot until the
// output register is free; the next score stalls only while it is there.
// ----------------------------------------------------------------------------
module factorization_machine_score_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  fms_req_if.sink   req_i,
  fms_rsp_if.source rsp_o,
  fms_cfg_if.sink   cfg_i
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_LIN_WAIT = 9'b000000010,
    ST_LIN_MUL  = 9'b000000100,
    ST_FAC_WAIT = 9'b000001000,
    ST_FAC_MUL1 = 9'b000010000,
    ST_FAC_MUL2 = 9'b000100000,
    ST_SC_START = 9'b001000000,
    ST_SC_MUL   = 9'b010000000,
    ST_SC_ADD   = 9'b100000000
  } state_e;

  // EMIT handled in SC paths via out slot check
  localparam int KW = fms_pkg::FacW + 1;

  state_e state_q, state_d;

  // config
  logic [10:0] feat_use_q;
  logic [3:0]  fac_use_q;
  logic [2:0]  tgt_use_q;
  logic [KW-1:0] nk;

  // latched request
  logic [fms_pkg::TgtW-1:0]  tg_q, tg_d;
  logic [fms_pkg::FeatW-1:0] fi_q, fi_d;
  logic signed [31:0]        val_q, val_d;
  logic                      last_q, last_d;
  logic [KW-1:0]             k_q, k_d;

  // accumulators
  logic signed [63:0] lin_acc_q, lin_acc_d;
  logic signed [63:0] s1_q [fms_pkg::MaxFactors];
  logic signed [63:0] s1_d [fms_pkg::MaxFactors];
  logic signed [63:0] s2_q [fms_pkg::MaxFactors];
  logic signed [63:0] s2_d [fms_pkg::MaxFactors];
  logic signed [63:0] score_q, score_d;
  logic signed [63:0] diff_q, diff_d;
  logic               rej_q, rej_d;
  logic               emit_q, emit_d;
  logic signed [31:0] bias_q [fms_pkg::MaxTargets];

  // output register
  logic               out_valid_q, out_valid_d;
  logic signed [63:0] out_score_q, out_score_d;
  logic               out_rej_q, out_rej_d;

  // tables and multiplier
  logic        req_acc;
  logic        lin_we, fac_we, lin_re, fac_re;
  logic [31:0] lin_rdata, fac_rdata;
  logic [fms_pkg::FacW-1:0] fac_k;
  logic        tg_ok_in, contrib;
  fms_pkg::mul_req_t mreq;
  fms_pkg::mul_rsp_t mrsp;

  assign req_acc  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE) && !emit_q;
  assign cfg_i.ready = 1'b1;
  assign nk = (fac_use_q > 4'(fms_pkg::MaxFactors)) ? KW'(fms_pkg::MaxFactors)
                                                   : KW'(fac_use_q);
  assign tg_ok_in = {1'b0, req_i.target} < tgt_use_q;
  assign contrib  = tg_ok_in && ({1'b0, req_i.feature_index} < feat_use_q);

  assign lin_we = req_acc && (req_i.opcode == fms_pkg::OP_LINEAR);
  assign fac_we = req_acc && (req_i.opcode == fms_pkg::OP_FACTOR);

  fms_ram #(.Width(32), .Depth(fms_pkg::LinDepth)) u_lin_ram (
    .clk_i   (clk_i),
    .we_i    (lin_we),
    .waddr_i ({req_i.target, req_i.feature_index}),
    .wdata_i (req_i.value),
    .re_i    (lin_re),
    .raddr_i ({req_i.target, req_i.feature_index}),
    .rdata_o (lin_rdata)
  );

  fms_ram #(.Width(32), .Depth(fms_pkg::FacDepth)) u_fac_ram (
    .clk_i   (clk_i),
    .we_i    (fac_we),
    .waddr_i ({req_i.target, req_i.feature_index, req_i.factor_index}),
    .wdata_i (req_i.value),
    .re_i    (fac_re),
    .raddr_i ({tg_q, fi_q, fac_k}),
    .rdata_o (fac_rdata)
  );

  fms_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_comb begin
    state_d     = state_q;
    tg_d        = tg_q;
    fi_d        = fi_q;
    val_d       = val_q;
    last_d      = last_q;
    k_d         = k_q;
    lin_acc_d   = lin_acc_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    score_d     = score_q;
    diff_d      = diff_q;
    rej_d       = rej_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q;
    out_score_d = out_score_q;
    out_rej_d   = out_rej_q;
    lin_re      = 1'b0;
    fac_re      = 1'b0;
    fac_k       = k_q[fms_pkg::FacW-1:0];
    mreq.start  = 1'b0;
    mreq.a      = fms_pkg::sext32(val_q);
    mreq.b      = fms_pkg::sext32(val_q);

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    // finished score moves to the output register once it is free
    if (emit_q && (!out_valid_q || rsp_o.ready)) begin
      emit_d      = 1'b0;
      out_valid_d = 1'b1;
      out_score_d = score_q;
      out_rej_d   = rej_q;
      lin_acc_d   = '0;
      for (int i = 0; i < fms_pkg::MaxFactors; i++) begin
        s1_d[i] = '0;
        s2_d[i] = '0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          tg_d   = req_i.target;
          fi_d   = req_i.feature_index;
          val_d  = req_i.value;
          last_d = req_i.last;
          unique case (req_i.opcode)
            fms_pkg::OP_FEATURE: begin
              if (contrib) begin
                lin_re  = 1'b1;
                state_d = ST_LIN_WAIT;
              end else if (req_i.last) begin
                state_d = ST_SC_START;
              end
            end
            fms_pkg::OP_EVAL: state_d = ST_SC_START;
            default: ;
          endcase
        end
      end
      ST_LIN_WAIT: begin
        mreq.start = 1'b1;
        mreq.a     = fms_pkg::sext32(lin_rdata);
        state_d    = ST_LIN_MUL;
      end
      ST_LIN_MUL: begin
        if (mrsp.done) begin
          lin_acc_d = fms_pkg::sat_add(lin_acc_q, mrsp.res);
          k_d = '0;
          if (nk == '0) begin
            state_d = last_q ? ST_SC_START : ST_IDLE;
          end else begin
            fac_re  = 1'b1;
            fac_k   = '0;
            state_d = ST_FAC_WAIT;
          end
        end
      end
      ST_FAC_WAIT: begin
        mreq.start = 1'b1;
        mreq.a     = fms_pkg::sext32(fac_rdata);
        state_d    = ST_FAC_MUL1;
      end
      ST_FAC_MUL1: begin
        if (mrsp.done) begin
          s1_d[k_q[fms_pkg::FacW-1:0]] =
            fms_pkg::sat_add(s1_q[k_q[fms_pkg::FacW-1:0]], mrsp.res);
          mreq.start = 1'b1;
          mreq.a     = mrsp.res;
          mreq.b     = mrsp.res;
          state_d    = ST_FAC_MUL2;
        end
      end
      ST_FAC_MUL2: begin
        if (mrsp.done) begin
          s2_d[k_q[fms_pkg::FacW-1:0]] =
            fms_pkg::sat_add(s2_q[k_q[fms_pkg::FacW-1:0]], mrsp.res);
          k_d = k_q + KW'(1);
          if (k_q + KW'(1) == nk) begin
            state_d = last_q ? ST_SC_START : ST_IDLE;
          end else begin
            fac_re  = 1'b1;
            fac_k   = k_q[fms_pkg::FacW-1:0] + fms_pkg::FacW'(1);
            state_d = ST_FAC_WAIT;
          end
        end
      end
      ST_SC_START: begin
        // waits until the previous score has left the holding slot
        if (!emit_q) begin
          k_d = '0;
          if ({1'b0, tg_q} >= tgt_use_q) begin
            score_d = '0;
            rej_d   = 1'b1;
            emit_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            score_d = fms_pkg::sat_add(lin_acc_q, fms_pkg::sext32(bias_q[tg_q]));
            rej_d   = 1'b0;
            if (nk == '0) begin
              emit_d  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              mreq.start = 1'b1;
              mreq.a     = s1_q[0];
              mreq.b     = s1_q[0];
              state_d    = ST_SC_MUL;
            end
          end
        end
      end
      ST_SC_MUL: begin
        if (mrsp.done) begin
          diff_d  = fms_pkg::sat_sub(mrsp.res, s2_q[k_q[fms_pkg::FacW-1:0]]);
          state_d = ST_SC_ADD;
        end
      end
      ST_SC_ADD: begin
        score_d = fms_pkg::sat_add(score_q, fms_pkg::half(diff_q));
        k_d     = k_q + KW'(1);
        if (k_q + KW'(1) == nk) begin
          emit_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = s1_q[k_q[fms_pkg::FacW-1:0] + fms_pkg::FacW'(1)];
          mreq.b     = s1_q[k_q[fms_pkg::FacW-1:0] + fms_pkg::FacW'(1)];
          state_d    = ST_SC_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      feat_use_q  <= 11'd1024;
      fac_use_q   <= 4'd8;
      tgt_use_q   <= 3'd4;
      lin_acc_q   <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < fms_pkg::MaxFactors; i++) begin
        s1_q[i] <= '0;
        s2_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      lin_acc_q   <= lin_acc_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          fms_pkg::CFG_FEATURES: feat_use_q <= cfg_i.data;
          fms_pkg::CFG_FACTORS:  fac_use_q  <= cfg_i.data[3:0];
          fms_pkg::CFG_TARGETS:  tgt_use_q  <= cfg_i.data[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tg_q        <= tg_d;
    fi_q        <= fi_d;
    val_q       <= val_d;
    last_q      <= last_d;
    k_q         <= k_d;
    score_q     <= score_d;
    diff_q      <= diff_d;
    rej_q       <= rej_d;
    out_score_q <= out_score_d;
    out_rej_q   <= out_rej_d;
    if (req_acc && (req_i.opcode == fms_pkg::OP_BIAS)) begin
      bias_q[req_i.target] <= req_i.value;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.score           = out_score_q;
  assign rsp_o.target_rejected = out_rej_q;

endmodule

### dv/fms_score_checker.sv
// ----------------------------------------------------------------------------
// fms_score_checker: scoreboard for the FM scorer
// Mirrors tables, accumulators and config, predicts every score and compares
// each returned score with the oldest one predicted.
// ----------------------------------------------------------------------------
module fms_score_checker
  import fms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fms_req_if   req,
  fms_rsp_if   rsp,
  fms_cfg_if   cfg,
  output int   errors_o,
  output int   pending_o,
  output int   scores_o
);

  typedef struct {
    logic signed [63:0] score;
    logic               rejected;
  } score_t;

  logic signed [31:0] weight_mem [LinDepth];
  logic signed [31:0] factor_mem [FacDepth];
  logic signed [31:0] bias_mem   [MaxTargets];
  logic signed [63:0] lin_sum;
  logic signed [63:0] vx_sum [MaxFactors];
  logic signed [63:0] vx_sq_sum [MaxFactors];
  logic [10:0] feat_reg;
  logic [3:0]  fac_reg;
  logic [2:0]  tgt_reg;
  score_t      score_q[$];

  assign pending_o = score_q.size();

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? SatMin : SatMax;
    return r;
  endfunction

  function automatic logic signed [63:0] sub_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? SatMin : SatMax;
    return r;
  endfunction

  // exact product, scaled by 2^-16 toward zero, clamped to 64 bits
  function automatic logic signed [63:0] qmul(logic signed [63:0] a,
                                              logic signed [63:0] b);
    logic signed [127:0] wa, wb, p, q;
    wa = a;
    wb = b;
    p  = wa * wb;
    q  = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
    if (q[127:63] != {65{q[127]}}) return q[127] ? SatMin : SatMax;
    return q[63:0];
  endfunction

  function automatic int used_factors();
    return (fac_reg > MaxFactors) ? MaxFactors : int'(fac_reg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    score_t exp_s, got;
    int row, nk;
    logic tg_ok;
    logic signed [63:0] t, acc;
    if (!rst_ni) begin
      lin_sum   = '0;
      vx_sum    = '{default: '0};
      vx_sq_sum = '{default: '0};
      feat_reg <= 11'd1024;
      fac_reg  <= 4'd8;
      tgt_reg  <= 3'd4;
      score_q.delete();
      errors_o = 0;
      scores_o = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_e'(cfg.index))
          CFG_FEATURES: feat_reg <= cfg.data;
          CFG_FACTORS:  fac_reg  <= cfg.data[3:0];
          CFG_TARGETS:  tgt_reg  <= cfg.data[2:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        row   = int'(req.target) * MaxFeatures + int'(req.feature_index);
        tg_ok = (req.target < tgt_reg);
        nk    = used_factors();
        case (req.opcode)
          OP_LINEAR: weight_mem[row] = req.value;
          OP_FACTOR: factor_mem[row * MaxFactors + int'(req.factor_index)] = req.value;
          OP_BIAS:   bias_mem[req.target] = req.value;
          OP_FEATURE, OP_EVAL: begin
            // feature contribution goes in first, then scoring on last/eval
            if (req.opcode == OP_FEATURE && tg_ok && req.feature_index < feat_reg) begin
              lin_sum = add_sat(lin_sum, qmul(weight_mem[row], req.value));
              for (int k = 0; k < nk; k++) begin
                t = qmul(factor_mem[row * MaxFactors + k], req.value);
                vx_sum[k]    = add_sat(vx_sum[k], t);
                vx_sq_sum[k] = add_sat(vx_sq_sum[k], qmul(t, t));
              end
            end
            if (req.opcode == OP_EVAL || req.last) begin
              if (!tg_ok) begin
                exp_s.score    = '0;
                exp_s.rejected = 1'b1;
              end else begin
                acc = add_sat(lin_sum, bias_mem[req.target]);
                for (int k = 0; k < nk; k++)
                  acc = add_sat(acc, sub_sat(qmul(vx_sum[k], vx_sum[k]), vx_sq_sum[k]) / 2);
                exp_s.score    = acc;
                exp_s.rejected = 1'b0;
              end
              score_q.push_back(exp_s);
              lin_sum = '0;
              for (int k = 0; k < MaxFactors; k++) begin
                vx_sum[k]    = '0;
                vx_sq_sum[k] = '0;
              end
            end
          end
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        scores_o++;
        got.score    = rsp.score;
        got.rejected = rsp.target_rejected;
        if (score_q.size() == 0) begin
          $display("%0t: unexpected score %h (rejected %b)", $time, got.score, got.rejected);
          errors_o++;
        end else begin
          exp_s = score_q.pop_front();
          if (got.score !== exp_s.score) begin
            $display("%0t: score mismatch expected %h got %h", $time, exp_s.score, got.score);
            errors_o++;
          end
          if (got.rejected !== exp_s.rejected) begin
            $display("%0t: target_rejected mismatch expected %b got %b",
                     $time, exp_s.rejected, got.rejected);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: FM scorer stimulus and verdict
// Preloads a pool of features, runs directed corner requests, then random
// feature lists over several config settings with random stalls both sides.
// ----------------------------------------------------------------------------
module testbench;
  import fms_pkg::*;

  localparam int WatchdogLimit = 12000; // idle cycles before we call it hung
  localparam int DrainCycles   = 300;   // covers the slowest feature and the slowest score
  localparam int PhaseRequests = 55;
  localparam int HoldCycles    = 1500;

  logic clk_i;
  logic rst_ni;

  fms_req_if req_if ();
  fms_rsp_if rsp_if ();
  fms_cfg_if cfg_if ();

  int errors, pending, scores;
  int idle_cycles;

  // which table entries have been loaded, so no unloaded entry is ever read
  bit weight_loaded [LinDepth];
  bit factor_loaded [FacDepth];
  int feat_lim, fac_lim, tgt_lim; // effective (clamped) config

  // feature indices that are fully loaded for every target; bits all toggle
  logic [9:0] pool [8] = '{10'd0, 10'd1, 10'd2, 10'h155, 10'h2AA, 10'h200,
                           10'h0FF, 10'h3FF};

  factorization_machine_score_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  fms_score_checker i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg      (cfg_if),
    .errors_o (errors),
    .pending_o(pending),
    .scores_o (scores)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: any accepted request, score or config write resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Score sink: random ready bursts, one long hold-off once traffic is going
  // so the output register fills and the request side backs up.
  initial begin
    bit held;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && scores >= 150) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(100, 300)
                                        : $urandom_range(1, 20)) @(posedge clk_i);
      rsp_if.ready <= 1'b0;
      repeat ($urandom_range(0, 19) == 0 ? $urandom_range(30, 120)
                                         : $urandom_range(1, 3)) @(posedge clk_i);
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      5, 6:          return $urandom;
      7:             return 32'h7FFF_FFFF;
      8:             return 32'h8000_0000;
      default:       return $urandom_range(0, 2) - 1;
    endcase
  endfunction

  // small values for pool entries so scores are not all saturated
  function automatic logic [31:0] pool_value();
    return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
  endfunction

  // true if a feature request would read entries never loaded
  function automatic bit reads_unloaded(logic [1:0] tg, logic [9:0] fi);
    int row;
    row = int'(tg) * MaxFeatures + int'(fi);
    if (tg >= tgt_lim || fi >= feat_lim) return 1'b0;
    if (!weight_loaded[row]) return 1'b1;
    for (int k = 0; k < fac_lim; k++)
      if (!factor_loaded[row * MaxFactors + k]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [9:0] pick_feature(logic [1:0] tg);
    logic [9:0] fi;
    fi = ($urandom_range(0, 3) == 0) ? 10'($urandom) : pool[$urandom_range(0, 7)];
    if (reads_unloaded(tg, fi)) fi = pool[$urandom_range(0, 7)];
    return fi;
  endfunction

  // Drive one request and hold it until accepted, then maybe idle a while.
  task automatic send(logic [2:0] op, logic [1:0] tg, logic [9:0] fi, logic [2:0] ki,
                      logic [31:0] val, logic lst);
    int gap, r;
    req_if.valid         <= 1'b1;
    req_if.opcode        <= op;
    req_if.target        <= tg;
    req_if.feature_index <= fi;
    req_if.factor_index  <= ki;
    req_if.value         <= val;
    req_if.last          <= lst;
    do @(posedge clk_i); while (!req_if.ready);
    if (op == OP_LINEAR) weight_loaded[int'(tg) * MaxFeatures + int'(fi)] = 1'b1;
    if (op == OP_FACTOR)
      factor_loaded[(int'(tg) * MaxFeatures + int'(fi)) * MaxFactors + int'(ki)] = 1'b1;
    r   = $urandom_range(0, 99);
    gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 80);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait for every predicted score, then let the core settle
  // (a feature without last has no score to wait on but may still be busy).
  task automatic drain();
    req_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [10:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_FEATURES: feat_lim = (data > MaxFeatures) ? MaxFeatures : int'(data);
      CFG_FACTORS:  fac_lim  = (data[3:0] > MaxFactors) ? MaxFactors : int'(data[3:0]);
      default:      tgt_lim  = (data[2:0] > MaxTargets) ? MaxTargets : int'(data[2:0]);
    endcase
  endtask

  // One random request group: mostly a feature list, some loads, evals and noise.
  task automatic random_group();
    logic [1:0] tg, ftg;
    int len, r;
    r  = $urandom_range(0, 99);
    tg = 2'($urandom);
    if (r < 70) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        ftg = ($urandom_range(0, 9) == 0) ? 2'($urandom) : tg;
        // a list that never ends is a broken sequence; it runs into the next
        send(OP_FEATURE, ftg, pick_feature(ftg), 3'($urandom), rand_value(),
             (i == len - 1) && ($urandom_range(0, 19) != 0));
      end
    end else if (r < 85) begin
      case ($urandom_range(0, 2))
        0:       send(OP_LINEAR, tg, 10'($urandom), 3'($urandom), rand_value(), 1'($urandom));
        1:       send(OP_FACTOR, tg, 10'($urandom), 3'($urandom), rand_value(), 1'($urandom));
        default: send(OP_BIAS, tg, 10'($urandom), 3'($urandom), pool_value(), 1'($urandom));
      endcase
    end else if (r < 93) begin
      send(OP_EVAL, tg, 10'($urandom), 3'($urandom), rand_value(), 1'($urandom));
    end else begin
      // unknown opcodes must be dropped silently
      send(3'($urandom_range(5, 7)), tg, 10'($urandom), 3'($urandom), $urandom,
           1'($urandom));
    end
  endtask

  initial begin
    logic [10:0] settings [7][3];
    bit failed;
    settings = '{'{11'd1024, 11'd8, 11'd4}, '{11'd2047, 11'd15, 11'd7},
                 '{11'd1, 11'd1, 11'd1},     '{11'd0, 11'd0, 11'd0},
                 '{11'd700, 11'd3, 11'd2},   '{11'd300, 11'd5, 11'd3},
                 '{11'd1024, 11'd8, 11'd4}};
    feat_lim = MaxFeatures;
    fac_lim  = MaxFactors;
    tgt_lim  = MaxTargets;
    req_if.valid <= 1'b0;
    req_if.opcode <= OP_EVAL;
    req_if.target <= '0;
    req_if.feature_index <= '0;
    req_if.factor_index <= '0;
    req_if.value <= '0;
    req_if.last <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_FEATURES;
    cfg_if.data <= '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Table preload: for every target, its bias, then every pool feature.
    for (int t = 0; t < MaxTargets; t++) begin
      send(OP_BIAS, 2'(t), '0, '0, pool_value(), 1'b0);
      for (int p = 0; p < 8; p++) begin
        send(OP_LINEAR, 2'(t), pool[p], '0, pool_value(), 1'b1);
        for (int k = 0; k < MaxFactors; k++)
          send(OP_FACTOR, 2'(t), pool[p], 3'(k), pool_value(), 1'b0);
      end
    end

    // Directed corners: extreme weights/values that saturate, empty evals, unknown opcodes, bias extremes.
    send(OP_LINEAR, 2'd3, 10'h3FF, '0, 32'h7FFF_FFFF, 1'b0);
    for (int k = 0; k < MaxFactors; k++)
      send(OP_FACTOR, 2'd3, 10'h3FF, 3'(k), 32'h8000_0000, 1'b0);
    send(OP_FEATURE, 2'd3, 10'h3FF, 3'd7, 32'h7FFF_FFFF, 1'b1);
    send(OP_FEATURE, 2'd3, 10'h3FF, '0, 32'h8000_0000, 1'b0);
    send(OP_FEATURE, 2'd3, 10'h3FF, '0, 32'h8000_0000, 1'b1);
    send(OP_FEATURE, 2'd0, 10'd0, '0, 32'h0001_0000, 1'b1);
    send(OP_EVAL, 2'd0, '0, '0, '0, 1'b0);           // empty list
    send(OP_EVAL, 2'd2, '0, '0, '0, 1'b1);
    send(3'd5, 2'd1, 10'h3FF, 3'd7, 32'hFFFF_FFFF, 1'b1);
    send(3'd6, 2'd2, 10'h155, '0, 32'h1234_5678, 1'b1);
    send(3'd7, 2'd3, 10'h2AA, 3'd5, 32'h8000_0000, 1'b1);
    send(OP_BIAS, 2'd1, '0, '0, 32'h8000_0000, 1'b0);
    send(OP_EVAL, 2'd1, '0, '0, '0, 1'b0);
    send(OP_BIAS, 2'd1, '0, '0, 32'h7FFF_FFFF, 1'b0);
    send(OP_FEATURE, 2'd1, 10'h2AA, '0, 32'h7FFF_FFFF, 1'b1);

    // Config phases, written only with the core idle.
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      write_cfg(CFG_FEATURES, settings[ph][0]);
      write_cfg(CFG_FACTORS, settings[ph][1]);
      write_cfg(CFG_TARGETS, settings[ph][2]);
      for (int n = 0; n < PhaseRequests; n++) begin
        if (ph == 2 && n == PhaseRequests / 2) begin
          // sender pause until every score is back, no config change
          req_if.valid <= 1'b0;
          repeat (2) @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        random_group();
      end
    end

    drain();
    failed = (errors != 0) || (pending != 0);
    if (pending != 0) $display("%0t: %0d scores never returned", $time, pending);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/fms_pkg.sv
hw/rtl/fms_req_if.sv
hw/rtl/fms_rsp_if.sv
hw/rtl/fms_cfg_if.sv
hw/rtl/fms_ram.sv
hw/rtl/fms_mul.sv
hw/rtl/factorization_machine_score_core.sv
dv/fms_score_checker.sv
dv/testbench.sv
